FILE: design/u8sd_pkg.sv
// Package for the UTF-8 stream decoder.
// Holds the status codes, beat and result types and the byte constants.
// No dependencies; every other file imports it.
package u8sd_pkg;

  localparam int unsigned CP_BITS  = 31;
  localparam int unsigned LN_BITS  = 32;
  localparam int unsigned REM_BITS = 3;

  localparam logic [7:0] LF_BYTE = 8'h0A;

  // Result status codes
  typedef enum logic [1:0] {
    ST_CHAR      = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // One input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    logic [LN_BITS-1:0] line_number;
    status_t            status;
    logic               final_result;
  } result_t;

endpackage

FILE: design/u8sd_ifs.sv
// Valid/ready channel interfaces of the UTF-8 stream decoder.
// Depends on u8sd_pkg for the status type and field widths.
interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface u8sd_out_if import u8sd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CP_BITS-1:0] code_point;
  logic [LN_BITS-1:0] line_number;
  status_t            status;
  logic               final_result;

  modport source (output valid, code_point, line_number, status, final_result, input ready);
  modport sink   (input valid, code_point, line_number, status, final_result, output ready);
endinterface

FILE: design/u8sd_in_stage.sv
// Input register of the UTF-8 stream decoder.
// Depends on u8sd_pkg for the beat type.
module u8sd_in_stage import u8sd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  input  logic     advance,
  output logic     beat_valid_r,
  output in_beat_t beat_r
);

  logic beat_valid_nxt;

  // Take a new beat when empty or when the held beat moves on
  assign in_ready = !beat_valid_r || advance;

  always_comb begin
    beat_valid_nxt = beat_valid_r;
    if (in_ready) begin
      beat_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else begin
      beat_valid_r <= beat_valid_nxt;
    end
  end

  // Payload holds while the stage is stalled
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_data;
    end
  end

endmodule

FILE: design/u8sd_decode.sv
// Decode step of the UTF-8 stream decoder: sequence state, line counter
// and the combinational decode of one byte. Depends on u8sd_pkg.
module u8sd_decode import u8sd_pkg::*; #(
  parameter int unsigned LINE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_beat_t beat,
  output logic     res_emit,
  output result_t  res
);

  logic [CP_BITS-1:0]   part_r, part_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 disc_r, disc_nxt;

  logic [7:0]          b;
  logic [4:0]          lead_mask;
  logic [REM_BITS-1:0] lead_len;
  logic [CP_BITS-1:0]  shifted;
  logic [LN_BITS-1:0]  line_out;

  assign b       = beat.data_byte;
  assign shifted = {part_r[CP_BITS-7:0], b[5:0]};

  // Report the low 32 bits of the line counter, zero-extended when it is narrower
  generate
    if (LINE_BITS >= LN_BITS) begin : g_line_trunc
      assign line_out = line_r[LN_BITS-1:0];
    end else begin : g_line_ext
      assign line_out = {{(LN_BITS - LINE_BITS){1'b0}}, line_r};
    end
  endgenerate

  // Classify the lead byte: sequence length and payload mask
  always_comb begin
    lead_mask = 5'h00;
    lead_len  = 3'd0;
    if (b inside {[8'hC0:8'hDF]}) begin
      lead_mask = 5'h1F;
      lead_len  = 3'd1;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      lead_mask = 5'h0F;
      lead_len  = 3'd2;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      lead_mask = 5'h07;
      lead_len  = 3'd3;
    end else if (b inside {[8'hF8:8'hFB]}) begin
      lead_mask = 5'h03;
      lead_len  = 3'd4;
    end else if (b inside {[8'hFC:8'hFD]}) begin
      lead_mask = 5'h01;
      lead_len  = 3'd5;
    end
  end

  // Advance the sequence state and form the result of this byte
  always_comb begin
    part_nxt         = part_r;
    rem_nxt          = rem_r;
    line_nxt         = line_r;
    disc_nxt         = disc_r;
    res_emit         = 1'b0;
    res.code_point   = '0;
    res.line_number  = line_out;
    res.status       = ST_CHAR;
    res.final_result = beat.stream_end;
    if (step) begin
      if (disc_r) begin
        // drop bytes until the end of the stream
      end else if (rem_r != '0) begin
        part_nxt = shifted;
        rem_nxt  = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          res_emit       = 1'b1;
          res.code_point = shifted;
          part_nxt       = '0;
        end else if (beat.stream_end) begin
          res_emit   = 1'b1;
          res.status = ST_TRUNCATED;
        end
      end else if (!b[7]) begin
        res_emit       = 1'b1;
        res.code_point = {{(CP_BITS - 8){1'b0}}, b};
        if (b == LF_BYTE && line_r != '1) begin
          line_nxt = line_r + LINE_BITS'(1);
        end
      end else if (lead_len == '0) begin
        res_emit         = 1'b1;
        res.status       = ST_BAD_LEAD;
        res.final_result = 1'b1;
        disc_nxt         = 1'b1;
      end else if (beat.stream_end) begin
        res_emit   = 1'b1;
        res.status = ST_TRUNCATED;
      end else begin
        part_nxt = {{(CP_BITS - 5){1'b0}}, b[4:0] & lead_mask};
        rem_nxt  = lead_len;
      end
      // Return to the start state after the stream's last byte
      if (beat.stream_end) begin
        part_nxt = '0;
        rem_nxt  = '0;
        line_nxt = LINE_BITS'(1);
        disc_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      rem_r  <= '0;
      line_r <= LINE_BITS'(1);
      disc_r <= 1'b0;
    end else begin
      part_r <= part_nxt;
      rem_r  <= rem_nxt;
      line_r <= line_nxt;
      disc_r <= disc_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && beat.stream_end |=> line_r == LINE_BITS'(1) && rem_r == '0 && !disc_r)
    else $error("state not cleared after end of stream");

  a_disc_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> rem_r == '0)
    else $error("sequence open while dropping");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd5)
    else $error("continuation count out of range");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    res_emit && res.status != ST_CHAR |-> res.final_result && res.code_point == '0)
    else $error("error result not final or not zero");

endmodule

FILE: design/u8sd_out_stage.sv
// Result register of the UTF-8 stream decoder.
// Depends on u8sd_pkg for the result type.
module u8sd_out_stage import u8sd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_valid,
  input  result_t load_data,
  output logic    advance,
  output logic    out_valid_r,
  input  logic    out_ready,
  output result_t out_data_r
);

  logic out_valid_nxt;

  // Move on when the register is empty or its beat is taken
  assign advance = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      out_data_r <= load_data;
    end
  end

endmodule

FILE: design/utf8_stream_decoder.sv
// Streaming UTF-8 decoder: 1 to 6 byte forms to 31-bit code points with line numbers.
// Depends on u8sd_pkg, u8sd_ifs, u8sd_in_stage, u8sd_decode, u8sd_out_stage.
//
// The decoder takes one byte per clock cycle while the result side does not
// stall and gives at most one result per byte: the byte is held in the input
// register and then decoded into the result register. The rate is set
// by the single decode step between those registers, which updates the
// sequence state and line counter on each decoded byte, so bytes may follow
// back to back while the result register drains. A stall on the result
// side holds both registers and lowers in_beat.ready once the input
// register holds a beat. A bad lead byte or a
// stream that ends inside a sequence gives one error result with
// final_result set; the rest of that stream is dropped. The line counter
// is LINE_BITS wide and saturates; line_number carries its low 32 bits.
module utf8_stream_decoder import u8sd_pkg::*; #(
  parameter int unsigned LINE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  u8sd_in_if.sink           in_beat,
  u8sd_out_if.source        out_beat
);

  in_beat_t in_data;
  in_beat_t beat_r;
  logic     beat_valid_r;
  logic     advance;
  logic     step;
  logic     res_emit;
  result_t  res;
  result_t  out_data_r;
  logic     out_valid_r;

  assign in_data.data_byte  = in_beat.data_byte;
  assign in_data.stream_end = in_beat.stream_end;

  u8sd_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_beat.valid),
    .in_ready     (in_beat.ready),
    .in_data      (in_data),
    .advance      (advance),
    .beat_valid_r (beat_valid_r),
    .beat_r       (beat_r)
  );

  // Decode the held beat whenever the result register can take its result
  assign step = beat_valid_r && advance;

  u8sd_decode #(
    .LINE_BITS (LINE_BITS)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .beat     (beat_r),
    .res_emit (res_emit),
    .res      (res)
  );

  u8sd_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_valid  (res_emit),
    .load_data   (res),
    .advance     (advance),
    .out_valid_r (out_valid_r),
    .out_ready   (out_beat.ready),
    .out_data_r  (out_data_r)
  );

  assign out_beat.valid        = out_valid_r;
  assign out_beat.code_point   = out_data_r.code_point;
  assign out_beat.line_number  = out_data_r.line_number;
  assign out_beat.status       = out_data_r.status;
  assign out_beat.final_result = out_data_r.final_result;

endmodule
